// ----- rtl/core/tacho_averaged_pid_motor_drive_defines.svh -----
// Assertion macros shared by the drive's RTL files.
`ifndef TACHO_AVERAGED_PID_MOTOR_DRIVE_DEFINES_SVH
`define TACHO_AVERAGED_PID_MOTOR_DRIVE_DEFINES_SVH
// Assert an implication on every clock edge outside reset.
`define TAPD_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define TAPD_ASSERT_NEXT(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// ----- rtl/core/tapd_pkg.sv -----
// Package: shared types and constants of the tacho PID drive.
package tapd_pkg;
    localparam int unsigned STALE_US = 10000;
    localparam logic [25:0] US_PER_MIN = 26'd60000000;
    localparam int unsigned MS_PER_S = 1000;

    typedef enum logic [2:0] {
        REG_KP = 3'd0, REG_KI = 3'd1, REG_KD = 3'd2, REG_PERIOD = 3'd3,
        REG_MIN = 3'd4, REG_MAX = 3'd5, REG_PPR = 3'd6, REG_SWAP = 3'd7
    } reg_idx_t;

    // Request and status between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage

// ----- rtl/core/tapd_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, unsigned 64-bit.
`include "tacho_averaged_pid_motor_drive_defines.svh"
module tapd_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  tapd_pkg::div_req_t req,
    output tapd_pkg::div_rsp_t rsp
);
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[63:0], quo_reg[63]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift one dividend bit into the remainder, trial subtract
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `TAPD_ASSERT_NEXT(a_div_done_once, aclk, aresetn, done_reg, !done_reg, "divider done held")
    `TAPD_ASSERT_IMP(a_div_cnt_idle, aclk, aresetn, !busy_reg, cnt_reg == 7'd0, "count left")
    `TAPD_ASSERT_NEXT(a_div_start, aclk, aresetn, req.start, busy_reg, "start not taken")
endmodule

// ----- rtl/core/tacho_averaged_pid_motor_drive.sv -----
// Top level: tacho-averaged PID motor drive with serial divide and multiply.
//  channel | dir | tdata / payload                          | tuser
//  s_      | in  | time_us[31:0], target_rpm[47:32]         | kind
//  m_      | out | measured_rpm, drive_value, pin_a, pin_b   | -
//  cfg_    | in  | cfg_index[2:0], cfg_data[23:0]           | -
// A pulse holds the input through S_PDIV and one 64-step divide in S_PWAIT, or only S_PDIV when no time has passed.
// A tick runs these steps from acceptance to m_tvalid: ring sum, mean divide,
// three 24-step shift-add multiplies, integral and derivative divides, two output steps;
// a stale ring skips the sum and the mean divide. One item is in work at a time.
// Reset (aresetn low, synchronous) clears the ring valid state and the PID state.
// s_tready falls while an item is in work; a finished tick holds in S_OUT while a word waits.
`include "tacho_averaged_pid_motor_drive_defines.svh"
module tacho_averaged_pid_motor_drive #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // time_us[31:0], target_rpm[47:32]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // measured_rpm[7:0], drive_value[18:8],
                                   // pin_a_duty[28:19], pin_b_duty[38:29]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int IW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int CW = $clog2(SAMPLE_COUNT + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001, S_PDIV  = 12'b000000000010,
        S_PWAIT = 12'b000000000100, S_SUM   = 12'b000000001000,
        S_MDIV  = 12'b000000010000, S_MUL   = 12'b000000100000,
        S_IDIV  = 12'b000001000000, S_IWAIT = 12'b000010000000,
        S_DDIV  = 12'b000100000000, S_DWAIT = 12'b001000000000,
        S_UOUT  = 12'b010000000000, S_OUT   = 12'b100000000000
    } state_t;

    state_t st_reg, st_next;

    logic [23:0] kp_reg, ki_reg, kd_reg;
    logic [15:0] period_reg, ppr_reg;
    logic signed [10:0] min_reg, max_reg;
    logic swap_reg;

    logic [7:0]  ring_reg [SAMPLE_COUNT];
    logic [SAMPLE_COUNT-1:0] vld_reg, vld_next;
    logic [IW-1:0] widx_reg, widx_next;
    logic ring_full_reg, ring_full_next;
    logic [31:0] last_reg, last_next;
    logic signed [47:0] integ_reg, integ_next;
    logic signed [17:0] prev_reg, prev_next;

    logic [31:0] time_reg, time_next;
    logic signed [15:0] tgt_reg, tgt_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW+7:0] sum_reg, sum_next;
    logic [7:0] rpm_reg, rpm_next;
    logic signed [17:0] err_reg, err_next;
    // shift-add multiplier: 24-bit multiplier word, one bit per cycle
    logic [1:0]  mk_reg, mk_next;
    logic [4:0]  mc_reg, mc_next;
    logic [23:0] mb_reg, mb_next;
    logic signed [63:0] ma_reg, ma_next;
    logic signed [63:0] macc_reg, macc_next;
    logic signed [63:0] p_reg, p_next, iprod_reg, iprod_next, dprod_reg, dprod_next;
    logic signed [63:0] d_reg, d_next;
    logic signed [49:0] u_reg, u_next;
    logic neg_reg, neg_next;
    logic [39:0] out_reg, out_next;
    logic ovalid_reg, ovalid_next;

    tapd_pkg::div_req_t dreq;
    tapd_pkg::div_rsp_t drsp;

    tapd_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic [31:0] elapsed;
    logic [15:0] ppr_eff, dt_eff;
    logic [47:0] den;
    logic signed [34:0] edt;
    logic [7:0]  sample;
    logic        ring_wr;
    logic [15:0] abs_tgt;
    logic signed [65:0] usum;
    logic signed [49:0] isum;
    logic signed [49:0] ucl;
    logic signed [10:0] u11, drv;
    logic [10:0] mag;
    logic [9:0]  fwd, rev;
    logic [63:0] absv;

    assign elapsed  = time_reg - last_reg;
    assign ppr_eff  = (ppr_reg == 16'd0) ? 16'd1 : ppr_reg;
    assign dt_eff   = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign den      = elapsed * ppr_eff;
    assign edt      = err_reg * $signed({1'b0, dt_eff});
    assign s_tready = (st_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign sample   = (drsp.quotient > 64'd255) ? 8'd255 : drsp.quotient[7:0];
    assign abs_tgt  = tgt_reg[15] ? 16'(-tgt_reg) : 16'(tgt_reg);

    always_comb begin
        st_next = st_reg;
        vld_next = vld_reg; widx_next = widx_reg; ring_full_next = ring_full_reg;
        last_next = last_reg; integ_next = integ_reg; prev_next = prev_reg;
        time_next = time_reg; tgt_next = tgt_reg; ptr_next = ptr_reg; n_next = n_reg;
        sum_next = sum_reg; rpm_next = rpm_reg; err_next = err_reg;
        mk_next = mk_reg; mc_next = mc_reg; mb_next = mb_reg; ma_next = ma_reg;
        macc_next = macc_reg; p_next = p_reg; iprod_next = iprod_reg;
        dprod_next = dprod_reg; d_next = d_reg; u_next = u_reg; neg_next = neg_reg;
        out_next = out_reg; ovalid_next = ovalid_reg;
        dreq = '0; ring_wr = 1'b0;
        usum = '0; isum = '0; ucl = '0; u11 = '0; drv = '0; mag = '0;
        fwd = '0; rev = '0; absv = '0;
        if (ovalid_reg && m_tready) ovalid_next = 1'b0;
        case (st_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    time_next = s_tdata[31:0];
                    tgt_next  = s_tdata[47:32];
                    st_next   = s_tuser ? S_SUM : S_PDIV;
                    ptr_next  = '0;
                    sum_next  = '0;
                end
            end
            S_PDIV: begin
                dreq.start    = 1'b1;
                dreq.dividend = {38'd0, tapd_pkg::US_PER_MIN};
                dreq.divisor  = 64'(den);
                st_next = S_PWAIT;
                if (elapsed == 32'd0) begin
                    dreq.start = 1'b0;
                    ring_wr = 1'b1;
                    st_next = S_IDLE;
                end
            end
            S_PWAIT: begin
                if (drsp.done) begin
                    ring_wr = 1'b1;
                    st_next = S_IDLE;
                end
            end
            S_SUM: begin
                // stale ring: drop all samples before averaging
                if (ptr_reg == '0 && elapsed > tapd_pkg::STALE_US &&
                    (ring_full_reg || widx_reg != '0)) begin
                    vld_next = '0; widx_next = '0; ring_full_next = 1'b0;
                    n_next = '0;
                    st_next = S_MDIV;
                end else begin
                    if (vld_reg[ptr_reg]) sum_next = sum_reg + (IW+8)'(ring_reg[ptr_reg]);
                    n_next = ring_full_reg ? CW'(SAMPLE_COUNT) : CW'(widx_reg);
                    if (32'(ptr_reg) == SAMPLE_COUNT - 1) begin
                        st_next = S_MDIV;
                        ptr_next = '0;
                    end else begin
                        ptr_next = ptr_reg + IW'(1);
                    end
                end
            end
            S_MDIV: begin
                if (n_reg == '0) begin
                    rpm_next = 8'd0;
                    st_next = S_MUL;
                end else if (ptr_reg == '0) begin
                    // launch the mean divide once, then wait for it
                    dreq.start = 1'b1;
                    dreq.dividend = 64'(sum_reg);
                    dreq.divisor  = 64'(n_reg);
                    ptr_next = '1;
                end else if (drsp.done) begin
                    rpm_next = drsp.quotient[7:0];
                    st_next = S_MUL;
                end
                if (st_next == S_MUL) begin
                    if (tgt_reg == 16'sd0) begin
                        integ_next = '0; prev_next = '0;
                    end
                    err_next = 18'(signed'({2'b0, abs_tgt})) -
                               18'(signed'({10'b0, rpm_next}));
                    mk_next = 2'd0; mc_next = 5'd0;
                    mb_next = kp_reg;
                    ma_next = 64'(signed'(err_next));
                    macc_next = '0;
                end
            end
            S_MUL: begin
                // one multiplier bit per cycle: kp*e, then ki*e*dt, then kd*(e-prev)*1000
                if (mb_reg[0]) macc_next = macc_reg + ma_reg;
                ma_next = ma_reg <<< 1;
                mb_next = mb_reg >> 1;
                mc_next = mc_reg + 5'd1;
                if (mc_reg == 5'd23) begin
                    mc_next = '0;
                    case (mk_reg)
                        2'd0: begin
                            p_next = macc_next;
                            mk_next = 2'd1; mb_next = ki_reg;
                            ma_next = 64'(edt);
                            macc_next = '0;
                        end
                        2'd1: begin
                            iprod_next = macc_next;
                            mk_next = 2'd2; mb_next = kd_reg;
                            ma_next = 64'(signed'(err_reg - prev_reg)) *
                                      64'(tapd_pkg::MS_PER_S);
                            macc_next = '0;
                        end
                        default: begin
                            dprod_next = macc_next;
                            st_next = S_IDIV;
                            mk_next = '0;
                        end
                    endcase
                end
            end
            S_IDIV: begin
                neg_next = iprod_reg < 0;
                absv = iprod_reg < 0 ? 64'(-iprod_reg) : 64'(iprod_reg);
                dreq.start = 1'b1; dreq.dividend = absv;
                dreq.divisor = 64'(tapd_pkg::MS_PER_S);
                st_next = S_IWAIT;
            end
            S_IWAIT: begin
                if (drsp.done) begin
                    absv = neg_reg ? 64'(-drsp.quotient) : drsp.quotient;
                    isum = 50'(integ_reg) + 50'(signed'(absv));
                    if (isum > 50'sh7FFFFFFFFFFF) integ_next = 48'sh7FFFFFFFFFFF;
                    else if (isum < -50'sh800000000000) integ_next = 48'sh800000000000;
                    else integ_next = isum[47:0];
                    st_next = S_DDIV;
                end
            end
            S_DDIV: begin
                neg_next = dprod_reg < 0;
                absv = dprod_reg < 0 ? 64'(-dprod_reg) : 64'(dprod_reg);
                dreq.start = 1'b1; dreq.dividend = absv; dreq.divisor = 64'(dt_eff);
                st_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (drsp.done) begin
                    d_next = neg_reg ? signed'(-drsp.quotient) : signed'(drsp.quotient);
                    prev_next = err_reg;
                    st_next = S_UOUT;
                end
            end
            S_UOUT: begin
                usum = 66'(p_reg) + 66'(integ_reg) + 66'(d_reg);
                // truncate toward zero on the 2^16 scale
                if (usum < 0) usum = -((-usum) >>> 16);
                else usum = usum >>> 16;
                u_next = usum[49:0];
                st_next = S_OUT;
            end
            S_OUT: begin
                if (!ovalid_reg) begin
                    // clamp, apply the sign and split onto the pins
                    if (u_reg < 50'(min_reg)) ucl = 50'(min_reg);
                    else if (u_reg > 50'(max_reg)) ucl = 50'(max_reg);
                    else ucl = u_reg;
                    u11 = ucl[10:0];
                    drv = tgt_reg[15] ? -u11 : u11;
                    mag = drv[10] ? 11'(-drv) : 11'(drv);
                    fwd = (!drv[10] && drv != 0) ? mag[9:0] : 10'd0;
                    rev = drv[10] ? mag[9:0] : 10'd0;
                    out_next = {1'b0, swap_reg ? fwd : rev, swap_reg ? rev : fwd,
                                drv, rpm_reg};
                    ovalid_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
        if (ring_wr) begin
            vld_next[widx_reg] = 1'b1;
            last_next = time_reg;
            if (32'(widx_reg) == SAMPLE_COUNT - 1) begin
                widx_next = '0; ring_full_next = 1'b1;
            end else begin
                widx_next = widx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_wr) ring_reg[widx_reg] <= (st_reg == S_PDIV) ? 8'd255 : sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            kp_reg <= 24'd65536; ki_reg <= '0; kd_reg <= '0; period_reg <= 16'd20;
            min_reg <= '0; max_reg <= 11'sd255; ppr_reg <= 16'd1; swap_reg <= 1'b0;
            vld_reg <= '0; widx_reg <= '0; ring_full_reg <= 1'b0; last_reg <= '0;
            integ_reg <= '0; prev_reg <= '0; ovalid_reg <= 1'b0;
            mk_reg <= '0; mc_reg <= '0; ptr_reg <= '0;
        end else begin
            st_reg <= st_next;
            vld_reg <= vld_next; widx_reg <= widx_next; ring_full_reg <= ring_full_next;
            last_reg <= last_next; integ_reg <= integ_next; prev_reg <= prev_next;
            ovalid_reg <= ovalid_next;
            mk_reg <= mk_next; mc_reg <= mc_next; ptr_reg <= ptr_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tapd_pkg::REG_KP:     kp_reg <= cfg_data;
                    tapd_pkg::REG_KI:     ki_reg <= cfg_data;
                    tapd_pkg::REG_KD:     kd_reg <= cfg_data;
                    tapd_pkg::REG_PERIOD: period_reg <= cfg_data[15:0];
                    tapd_pkg::REG_MIN:    min_reg <= cfg_data[10:0];
                    tapd_pkg::REG_MAX:    max_reg <= cfg_data[10:0];
                    tapd_pkg::REG_PPR:    ppr_reg <= cfg_data[15:0];
                    tapd_pkg::REG_SWAP:   swap_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
        time_reg <= time_next; tgt_reg <= tgt_next; n_reg <= n_next;
        sum_reg <= sum_next; rpm_reg <= rpm_next; err_reg <= err_next;
        mb_reg <= mb_next; ma_reg <= ma_next; macc_reg <= macc_next;
        p_reg <= p_next; iprod_reg <= iprod_next; dprod_reg <= dprod_next;
        d_reg <= d_next; u_reg <= u_next; neg_reg <= neg_next; out_reg <= out_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    `TAPD_ASSERT_IMP(a_busy_no_ready, aclk, aresetn, st_reg != S_IDLE, !s_tready, "ready busy")
    `TAPD_ASSERT_IMP(a_full_widx, aclk, aresetn,
        !ring_full_reg && widx_reg == '0, vld_reg == '0, "valid without fill")
    `TAPD_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule
